@@ rtl/core/wwr_pkg.sv @@
`timescale 1ns / 1ps

package wwr_pkg;

  localparam int unsigned CharW              = 8;
  localparam int unsigned WidthW             = 8;
  localparam int unsigned DefaultRowBits     = 16;
  localparam int unsigned DefaultQueueDepth  = 2;
  localparam logic [WidthW-1:0] ScreenWidthReset = 8'd80;

  localparam logic [CharW-1:0] CharEnd     = 8'd0;
  localparam logic [CharW-1:0] CharNewline = 8'd10;
  localparam logic [CharW-1:0] CharSpace   = 8'd32;

  typedef enum logic [1:0] {
    KindEnd,
    KindNewline,
    KindSpace,
    KindChar
  } kind_e;

  typedef struct packed {
    kind_e kind;
  } item_t;

  function automatic kind_e classify(input logic [CharW-1:0] code);
    kind_e k;
    k = KindChar;
    if (code == CharEnd) begin
      k = KindEnd;
    end else if (code == CharNewline) begin
      k = KindNewline;
    end else if (code == CharSpace) begin
      k = KindSpace;
    end
    return k;
  endfunction

endpackage

@@ rtl/core/word_wrap_row_counter.sv @@
`timescale 1ns / 1ps
// Greedy word-wrap row counter.
// Text bytes arrive on the s_axis channel, one byte per transfer. A zero byte ends
// the text and produces one transfer on m_axis carrying the number of completed
// display rows, saturated at the maximum of RowBits bits; all other bytes produce
// nothing. The screen width is written through the cfg channel, which is always
// ready and may only be used while no text is in flight; it resets to 80.
// An end-of-text transfer passes the classifying input register, the two-entry
// queue and the output register of the wrap engine before m_axis_tvalid rises.
// The block takes one byte per cycle except when stalled behind a held result,
// as below; the wrap engine updates its line and row counters once per byte.
// When the receiver stalls, the result holds in the output register while the
// wrap engine keeps consuming ordinary bytes; only a further end-of-text byte
// waits, after which the queue and input register fill and s_axis_tready drops.
// Reset clears the line state, the row count and all valid flags and restores
// the screen width to 80.
module word_wrap_row_counter #(
  parameter int unsigned RowBits = wwr_pkg::DefaultRowBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] char_code
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  output logic [((RowBits+7)/8)*8-1:0] m_axis_tdata,   // [RowBits-1:0] row_count
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wwr_pkg::WidthW-1:0]   cfg_data_i
);

  localparam int unsigned OutW = ((RowBits + 7) / 8) * 8;

  wwr_pkg::item_t     fr_item, q_item;
  logic               fr_valid, fr_ready, q_valid, q_ready;
  logic [RowBits-1:0] row_count;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = OutW'(row_count);

  wwr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (s_axis_tdata),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_o  (fr_item),
    .valid_o (fr_valid),
    .ready_i (fr_ready)
  );

  wwr_queue #(
    .Depth (wwr_pkg::DefaultQueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (fr_item),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .pop_item_o   (q_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  wwr_back #(
    .RowBits (RowBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (q_item),
    .valid_i     (q_valid),
    .ready_o     (q_ready),
    .row_count_o (row_count),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready)
  );

endmodule

@@ rtl/core/wwr_front.sv @@
`timescale 1ns / 1ps

module wwr_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [wwr_pkg::CharW-1:0]  char_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  output wwr_pkg::item_t             item_o,
  output logic                       valid_o,
  input  logic                       ready_i
);

  logic           valid_q, valid_d;
  wwr_pkg::item_t item_q, item_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (ready_o) begin
      valid_d = valid_i;
      if (valid_i) begin
        item_d.kind = wwr_pkg::classify(char_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

@@ rtl/core/wwr_queue.sv @@
`timescale 1ns / 1ps

module wwr_queue #(
  parameter int unsigned Depth = wwr_pkg::DefaultQueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wwr_pkg::item_t push_item_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output wwr_pkg::item_t pop_item_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  wwr_pkg::item_t    mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/core/wwr_back.sv @@
`timescale 1ns / 1ps

module wwr_back #(
  parameter int unsigned RowBits = wwr_pkg::DefaultRowBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [wwr_pkg::WidthW-1:0]  cfg_data_i,
  input  wwr_pkg::item_t              item_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  output logic [RowBits-1:0]          row_count_o,
  output logic                        valid_o,
  input  logic                        ready_i
);

  localparam int unsigned W = wwr_pkg::WidthW;

  logic [W-1:0]       width_q;
  logic [W-1:0]       len_q, len_d;
  logic [W-1:0]       lsp_q, lsp_d;
  logic               seen_q, seen_d;
  logic [RowBits-1:0] rows_q, rows_d;
  logic               out_valid_q, out_valid_d;
  logic [RowBits-1:0] out_rows_q;
  logic               take, is_space, count;
  logic [W-1:0]       carry;

  assign ready_o     = (item_i.kind != wwr_pkg::KindEnd) || !out_valid_q || ready_i;
  assign take        = valid_i && ready_o;
  assign is_space    = (item_i.kind == wwr_pkg::KindSpace);
  assign valid_o     = out_valid_q;
  assign row_count_o = out_rows_q;

  always_comb begin
    len_d       = len_q;
    lsp_d       = lsp_q;
    seen_d      = seen_q;
    rows_d      = rows_q;
    count       = 1'b0;
    carry       = '0;
    out_valid_d = out_valid_q && !ready_i;
    if (take) begin
      case (item_i.kind)
        wwr_pkg::KindEnd: begin
          out_valid_d = 1'b1;
          len_d  = '0;
          lsp_d  = '0;
          seen_d = 1'b0;
          rows_d = '0;
        end
        wwr_pkg::KindNewline: begin
          count  = 1'b1;
          len_d  = '0;
          lsp_d  = '0;
          seen_d = 1'b0;
        end
        wwr_pkg::KindSpace, wwr_pkg::KindChar: begin
          if (len_q == '0 && is_space) begin
            count = 1'b0;
          end else if (width_q == '0) begin
            count  = 1'b1;
            len_d  = '0;
            lsp_d  = '0;
            seen_d = 1'b0;
          end else begin
            if (len_q >= width_q) begin
              count = 1'b1;
              if (seen_q && lsp_q < width_q) begin
                carry = width_q - W'(1) - lsp_q;
              end
              len_d  = carry;
              lsp_d  = '0;
              seen_d = 1'b0;
            end
            if (!(len_d == '0 && is_space)) begin
              if (is_space) begin
                lsp_d  = len_d;
                seen_d = 1'b1;
              end
              len_d = len_d + W'(1);
            end
          end
        end
        default: begin
          count = 1'b0;
        end
      endcase
      if (count && rows_q != '1) begin
        rows_d = rows_q + RowBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= wwr_pkg::ScreenWidthReset;
      len_q       <= '0;
      lsp_q       <= '0;
      seen_q      <= 1'b0;
      rows_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        width_q <= cfg_data_i;
      end
      len_q       <= len_d;
      lsp_q       <= lsp_d;
      seen_q      <= seen_d;
      rows_q      <= rows_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.kind == wwr_pkg::KindEnd) begin
      out_rows_q <= rows_q;
    end
  end

endmodule

@@ rtl/core/wwr_checker.sv @@
`timescale 1ns / 1ps

module wwr_checker #(
  parameter int unsigned RowBits = wwr_pkg::DefaultRowBits
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic [7:0]                   s_axis_tdata,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [((RowBits+7)/8)*8-1:0] m_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o
);

  localparam int unsigned OutW = ((RowBits + 7) / 8) * 8;

  // While no result is held, the input side is never stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no result pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tdata >> RowBits) == OutW'(0))
    else $error("padding bits of the result are not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready &&
      s_axis_tdata == wwr_pkg::CharEnd, 3) || !$past(m_axis_tready, 1) ||
      $past(s_axis_tvalid, 4) || $past(s_axis_tvalid, 5) || !$past(s_axis_tready, 3))
    else $error("result without a preceding end of text");

endmodule

bind word_wrap_row_counter wwr_checker #(.RowBits(RowBits)) u_wwr_checker (.*);
